FILE: hw/rtl/ae16_pkg.sv
// Shared types and constants for the 16-bit arithmetic encoder.
// No dependencies; imported by arithmetic_encoder_16bit_unit.
package ae16_pkg;

    localparam int unsigned IN_W   = 56;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CODE_W = 16;
    localparam int unsigned PROD_W = 32;

    localparam logic [CODE_W-1:0] HIGH_RESET  = 16'hffff;
    localparam logic [8:0]        PAT_EMPTY   = 9'h001;
    localparam logic [5:0]        MAX_RESULTS = 6'd36;
    localparam logic              CMD_ENCODE  = 1'b0;
    localparam logic              CMD_FINISH  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_HI,
        S_DIV_HI,
        S_MUL_LO,
        S_DIV_LO,
        S_SCAN,
        S_UNDER,
        S_EMIT,
        S_FLUSH
    } t_state;

endpackage

FILE: hw/rtl/arithmetic_encoder_16bit_unit.sv
// Top level of the 16-bit binary arithmetic encoder with byte output.
// Depends on ae16_pkg for the state type and constants.
//
// One request is handled at a time; o_s_tready is high only while idle. An encode
// request does two multiplies and two divisions on one shared restoring divider,
// then shifts out matching top bits (at most 16), takes underflow steps (at most
// 15), sends the coded bits with any pending bits released, and flushes; output
// stalls can hold it in the emit and flush states. An encode with a zero total
// returns to idle at once. A finish request sends the flushed and padding bits.
// Output bytes go through a one-byte hold stage and an output register, so tlast
// can mark the final byte of each request. Bytes beyond 36 in one request are
// dropped.
module arithmetic_encoder_16bit_unit #(
    parameter int unsigned PENDING_LIMIT = 255
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // command[0], sym_low[16:1], sym_high[32:17], total[48:33], zero above
    input  logic [ae16_pkg::IN_W-1:0]     i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // out_byte[7:0]
    output logic [ae16_pkg::BYTE_W-1:0]   o_m_tdata,
    output logic                          o_m_tlast,
    // overflow[0]
    output logic [0:0]                    o_m_tuser
);
    import ae16_pkg::*;

    localparam int unsigned PW = $clog2(PENDING_LIMIT + 1);
    localparam logic [PW-1:0] PLIM = PW'(PENDING_LIMIT);

    t_state r_state, n_state;
    logic              r_cmd, n_cmd;
    logic [CODE_W-1:0] r_lo_in, n_lo_in, r_hi_in, n_hi_in, r_tot, n_tot;
    logic [CODE_W-1:0] r_low, n_low, r_high, n_high, r_nh, n_nh;
    logic [PROD_W-1:0] r_range, n_range, r_q, n_q;
    logic [CODE_W-1:0] r_rem, n_rem;
    logic [4:0]        r_cnt, n_cnt;
    logic [PW-1:0]     r_pend, n_pend;
    logic [PW:0]       r_ecnt, n_ecnt;
    logic              r_ovf, n_ovf;
    logic [8:0]        r_pat, n_pat;
    logic [CODE_W-1:0] r_bits, n_bits;
    logic [4:0]        r_k, n_k;
    logic              r_first, n_first, r_b0, n_b0;
    logic              r_hold_v, n_hold_v, r_out_v, n_out_v;
    logic [7:0]        r_hold, n_hold, r_out, n_out;
    logic              r_out_last, n_out_last, r_out_ovf, n_out_ovf;
    logic [5:0]        r_nbyte, n_nbyte;

    logic              out_free, in_cmd, emit, bitv;
    logic [CODE_W:0]   div_t;
    logic              div_ge;
    logic [PROD_W-1:0] quot;
    logic [8:0]        pat_nx;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_ovf;
    assign out_free   = !r_out_v || i_m_tready;
    assign in_cmd     = i_s_tdata[0];

    // Shared restoring divider step, one quotient bit per cycle.
    assign div_t  = {r_rem, r_q[PROD_W-1]};
    assign div_ge = div_t >= {1'b0, r_tot};
    assign quot   = {r_q[PROD_W-2:0], div_ge};

    always_comb begin
        n_state = r_state;   n_cmd = r_cmd;     n_lo_in = r_lo_in;
        n_hi_in = r_hi_in;   n_tot = r_tot;     n_low = r_low;
        n_high = r_high;     n_nh = r_nh;       n_range = r_range;
        n_q = r_q;           n_rem = r_rem;     n_cnt = r_cnt;
        n_pend = r_pend;     n_ecnt = r_ecnt;   n_ovf = r_ovf;
        n_pat = r_pat;       n_bits = r_bits;   n_k = r_k;
        n_first = r_first;   n_b0 = r_b0;       n_hold_v = r_hold_v;
        n_hold = r_hold;     n_out_v = r_out_v; n_out = r_out;
        n_out_last = r_out_last; n_out_ovf = r_out_ovf;
        n_nbyte = r_nbyte;
        emit = 1'b0;
        bitv = 1'b0;
        pat_nx = r_pat;

        if (r_out_v && i_m_tready) begin
            n_out_v = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_cmd   = in_cmd;
                    n_lo_in = i_s_tdata[16:1];
                    n_hi_in = i_s_tdata[32:17];
                    n_tot   = i_s_tdata[48:33];
                    n_nbyte = '0;
                    if (in_cmd == CMD_FINISH) begin
                        n_bits  = {r_low[14], 15'd0};
                        n_first = 1'b1;
                        n_ecnt  = (PW+1)'(r_pend) + 1'b1;
                        n_k     = '0;
                        n_state = S_EMIT;
                    end else if (i_s_tdata[48:33] != '0) begin
                        n_range = {16'd0, r_high} - {16'd0, r_low} + 32'd1;
                        n_state = S_MUL_HI;
                    end
                end
            end
            S_MUL_HI: begin
                n_q = r_range * {16'd0, r_hi_in};
                n_rem = '0;
                n_cnt = '0;
                n_state = S_DIV_HI;
            end
            S_MUL_LO: begin
                n_q = r_range * {16'd0, r_lo_in};
                n_rem = '0;
                n_cnt = '0;
                n_state = S_DIV_LO;
            end
            S_DIV_HI, S_DIV_LO: begin
                n_rem = div_ge ? CODE_W'(div_t - {1'b0, r_tot}) : div_t[CODE_W-1:0];
                n_q = quot;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    if (r_state == S_DIV_HI) begin
                        n_nh = quot[CODE_W-1:0] - 16'd1 + r_low;
                        n_state = S_MUL_LO;
                    end else begin
                        n_low  = r_low + quot[CODE_W-1:0];
                        n_high = r_nh;
                        n_bits = r_low + quot[CODE_W-1:0];
                        n_k    = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_low[15] == r_high[15]) begin
                    n_low  = {r_low[14:0], 1'b0};
                    n_high = {r_high[14:0], 1'b1};
                    n_k    = r_k + 5'd1;
                end else begin
                    // Pending bits are released after the first decided bit.
                    if (r_k != '0) begin
                        n_first = 1'b1;
                        n_ecnt  = (PW+1)'(r_pend);
                        n_pend  = '0;
                        n_k     = r_k - 5'd1;
                    end else begin
                        n_first = 1'b0;
                        n_ecnt  = '0;
                    end
                    n_state = S_UNDER;
                end
            end
            S_UNDER: begin
                if (r_low[14] && !r_high[14]) begin
                    if (r_pend < PLIM) begin
                        n_pend = r_pend + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_low  = {1'b0, r_low[13:0], 1'b0};
                    n_high = {1'b1, r_high[13:0], 1'b1};
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_hold_v || out_free) begin
                    if (r_first) begin
                        emit = 1'b1;
                        bitv = r_bits[15];
                        n_b0 = r_bits[15];
                        n_bits = {r_bits[14:0], 1'b0};
                        n_first = 1'b0;
                    end else if (r_ecnt != '0) begin
                        emit = 1'b1;
                        bitv = !r_b0;
                        n_ecnt = r_ecnt - 1'b1;
                    end else if (r_k != '0) begin
                        emit = 1'b1;
                        bitv = r_bits[15];
                        n_bits = {r_bits[14:0], 1'b0};
                        n_k = r_k - 5'd1;
                    end else if (r_cmd == CMD_FINISH && r_pat != PAT_EMPTY) begin
                        emit = 1'b1;
                        bitv = 1'b0;
                    end else begin
                        n_state = S_FLUSH;
                    end
                    if (emit) begin
                        pat_nx = {r_pat[7:0], bitv};
                        n_pat = pat_nx;
                        if (pat_nx[8]) begin
                            // A completed byte past the per-request capacity is dropped.
                            if (r_nbyte < MAX_RESULTS) begin
                                if (r_hold_v) begin
                                    n_out_v = 1'b1;
                                    n_out = r_hold;
                                    n_out_last = 1'b0;
                                    n_out_ovf = r_ovf;
                                end
                                n_hold = pat_nx[7:0];
                                n_hold_v = 1'b1;
                                n_nbyte = r_nbyte + 6'd1;
                            end
                            n_pat = PAT_EMPTY;
                        end
                    end
                end
            end
            S_FLUSH: begin
                if (!r_hold_v || out_free) begin
                    if (r_hold_v) begin
                        n_out_v = 1'b1;
                        n_out = r_hold;
                        n_out_last = 1'b1;
                        n_out_ovf = r_ovf;
                        n_hold_v = 1'b0;
                    end
                    if (r_cmd == CMD_FINISH) begin
                        n_low  = '0;
                        n_high = HIGH_RESET;
                        n_pend = '0;
                        n_pat  = PAT_EMPTY;
                        n_ovf  = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_low    <= '0;
            r_high   <= HIGH_RESET;
            r_pend   <= '0;
            r_ovf    <= 1'b0;
            r_pat    <= PAT_EMPTY;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_first  <= 1'b0;
            r_ecnt   <= '0;
            r_k      <= '0;
            r_cnt    <= '0;
            r_cmd    <= CMD_ENCODE;
            r_nbyte  <= '0;
        end else begin
            r_state  <= n_state;
            r_low    <= n_low;
            r_high   <= n_high;
            r_pend   <= n_pend;
            r_ovf    <= n_ovf;
            r_pat    <= n_pat;
            r_hold_v <= n_hold_v;
            r_out_v  <= n_out_v;
            r_first  <= n_first;
            r_ecnt   <= n_ecnt;
            r_k      <= n_k;
            r_cnt    <= n_cnt;
            r_cmd    <= n_cmd;
            r_nbyte  <= n_nbyte;
        end
        r_lo_in    <= n_lo_in;
        r_hi_in    <= n_hi_in;
        r_tot      <= n_tot;
        r_nh       <= n_nh;
        r_range    <= n_range;
        r_q        <= n_q;
        r_rem      <= n_rem;
        r_bits     <= n_bits;
        r_b0       <= n_b0;
        r_hold     <= n_hold;
        r_out      <= n_out;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

`ifndef SYNTHESIS
    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !r_hold_v)
        else $error("byte left in hold stage while idle");
    a_pend_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PLIM)
        else $error("pending count above limit");
    a_pat_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pat != '0)
        else $error("bit packer lost its marker bit");
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_HI || r_state == S_DIV_LO) |-> r_rem < r_tot)
        else $error("divider remainder not below divisor");
`endif

endmodule

FILE: sim/tb_arithmetic_encoder_16bit_unit.sv
// Self-checking testbench for the 16-bit arithmetic encoder.
// Depends on ae16_pkg and arithmetic_encoder_16bit_unit; predicts coded bytes internally.
module tb_arithmetic_encoder_16bit_unit;
    import ae16_pkg::*;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last;
        logic       ovf;
    } t_coded;

    typedef struct {
        logic        cmd;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] tot;
        int          n_typed;    // -1: use the predictor only
        logic [7:0]  byte0;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [55:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;
    logic        o_m_tlast;
    logic [0:0]  o_m_tuser;

    arithmetic_encoder_16bit_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .o_m_tlast(o_m_tlast), .o_m_tuser(o_m_tuser)
    );

    // Predictor state of the coder.
    logic [15:0] code_low;
    logic [15:0] code_high;
    int unsigned under_count;
    logic [8:0]  byte_acc;
    logic        sat_flag;
    logic [7:0]  new_bytes[$];
    t_coded      coded_q[$];
    int          errors = 0;
    bit          stim_done = 0;
    bit          long_hold = 0;

    initial begin
        i_clk = 1'b0;
    end
    always #5 i_clk = ~i_clk;

    task automatic coder_reset();
        code_low = 16'h0000;
        code_high = HIGH_RESET;
        under_count = 0;
        byte_acc = PAT_EMPTY;
        sat_flag = 1'b0;
    endtask

    task automatic shift_bit(input logic b);
        byte_acc = {byte_acc[7:0], b};
        if (byte_acc[8]) begin
            if (new_bytes.size() < 36) new_bytes.push_back(byte_acc[7:0]);
            byte_acc = PAT_EMPTY;
        end
    endtask

    // Works out the bytes that one request produces and queues them.
    task automatic predict_coder(input logic cmd, input logic [15:0] lo,
                                 input logic [15:0] hi, input logic [15:0] tot);
        logic [31:0] span;
        logic [31:0] nh;
        logic [31:0] nl;
        new_bytes.delete();
        if (cmd == CMD_ENCODE) begin
            if (tot == 16'd0) return;
            span = {16'd0, code_high} - {16'd0, code_low} + 32'd1;
            nh = (span * hi) / tot - 32'd1 + code_low;
            nl = code_low + (span * lo) / tot;
            code_high = nh[15:0];
            code_low = nl[15:0];
            if (code_high[15] == code_low[15]) begin
                shift_bit(code_low[15]);
                while (under_count != 0) begin
                    under_count--;
                    shift_bit(~code_low[15]);
                end
                code_low = code_low << 1;
                code_high = {code_high[14:0], 1'b1};
                while (code_high[15] == code_low[15]) begin
                    shift_bit(code_low[15]);
                    code_low = code_low << 1;
                    code_high = {code_high[14:0], 1'b1};
                end
            end
            while (code_low[14] && !code_high[14]) begin
                if (under_count < 255) under_count++;
                else sat_flag = 1'b1;
                code_low = {1'b0, code_low[13:0], 1'b0};
                code_high = {code_high[14:0], 1'b1} | 16'h8001;
            end
        end else begin
            shift_bit(code_low[14]);
            for (int k = 0; k <= int'(under_count); k++) shift_bit(~code_low[14]);
            if (byte_acc != PAT_EMPTY) begin
                while (!byte_acc[8]) byte_acc = byte_acc << 1;
                if (new_bytes.size() < 36) new_bytes.push_back(byte_acc[7:0]);
                byte_acc = PAT_EMPTY;
            end
        end
        foreach (new_bytes[k])
            coded_q.push_back('{new_bytes[k], k == new_bytes.size() - 1, sat_flag});
        if (cmd == CMD_FINISH) coder_reset();
    endtask

    task automatic send_request(input logic cmd, input logic [15:0] lo,
                                input logic [15:0] hi, input logic [15:0] tot);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {7'd0, tot, hi, lo, cmd};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_coder(cmd, lo, hi, tot);
    endtask

    // Directed table. Typed rows: a first finish from reset gives 0x40 alone,
    // and a zero total gives nothing.
    t_row dir_rows[] = '{
        '{CMD_FINISH, 16'd0, 16'd1, 16'd1, 1, 8'h40},
        '{CMD_ENCODE, 16'd0, 16'd1, 16'd0, 0, 8'h00},
        '{CMD_ENCODE, 16'd0, 16'd1, 16'd2, -1, 8'h00},
        '{CMD_ENCODE, 16'd1, 16'd2, 16'd2, -1, 8'h00},
        '{CMD_ENCODE, 16'd0, 16'hffff, 16'hffff, -1, 8'h00},
        '{CMD_ENCODE, 16'hffff, 16'hffff, 16'hffff, -1, 8'h00},
        '{CMD_ENCODE, 16'd0, 16'd1, 16'hffff, -1, 8'h00},
        '{CMD_ENCODE, 16'd3, 16'd1, 16'd4, -1, 8'h00},
        '{CMD_ENCODE, 16'd1, 16'd9, 16'd4, -1, 8'h00},
        '{CMD_FINISH, 16'd0, 16'd0, 16'd0, -1, 8'h00},
        '{CMD_ENCODE, 16'd49, 16'd51, 16'd100, -1, 8'h00},
        '{CMD_ENCODE, 16'd49, 16'd51, 16'd100, -1, 8'h00},
        '{CMD_ENCODE, 16'd49, 16'd51, 16'd100, -1, 8'h00},
        '{CMD_ENCODE, 16'd0, 16'd1, 16'd3, -1, 8'h00},
        '{CMD_FINISH, 16'hffff, 16'hffff, 16'hffff, -1, 8'h00}
    };

    task automatic run_saturation();
        // Midpoint intervals keep the range straddling, driving the count to its limit.
        repeat (140) send_request(CMD_ENCODE, 16'd32767, 16'd32769, 16'hffff);
        send_request(CMD_ENCODE, 16'd0, 16'd1, 16'd4);
        send_request(CMD_FINISH, 16'd0, 16'd0, 16'd0);
    endtask

    initial begin
        int    nseq;
        int    pick;
        int    tot;
        int    lo;
        int    hi;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        coder_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_rows[r]) begin
            send_request(dir_rows[r].cmd, dir_rows[r].lo, dir_rows[r].hi, dir_rows[r].tot);
            if (dir_rows[r].n_typed >= 0) begin
                if (new_bytes.size() != dir_rows[r].n_typed) begin
                    $error("row %0d count expected %0d actual %0d", r,
                           dir_rows[r].n_typed, new_bytes.size());
                    errors++;
                end else if (dir_rows[r].n_typed > 0 &&
                             new_bytes[0] != dir_rows[r].byte0) begin
                    $error("row %0d out_byte expected %h actual %h", r,
                           dir_rows[r].byte0, new_bytes[0]);
                    errors++;
                end
            end
        end
        run_saturation();
        // Random part: sane model sequences dominate, with some ill-formed items.
        nseq = 0;
        while (nseq < 300) begin
            pick = $urandom_range(0, 19);
            tot = $urandom_range(1, 65535);
            if (pick < 3) tot = $urandom_range(1, 8);
            lo = $urandom_range(0, tot - 1);
            hi = $urandom_range(lo + 1, tot);
            if (pick == 19) begin
                send_request(CMD_FINISH, 16'($urandom), 16'($urandom), 16'($urandom));
            end else if (pick == 18) begin
                send_request(CMD_ENCODE, 16'($urandom), 16'($urandom), 16'($urandom));
            end else if (pick == 17) begin
                send_request(CMD_ENCODE, 16'($urandom), 16'($urandom), 16'd0);
            end else begin
                send_request(CMD_ENCODE, 16'(lo), 16'(hi), 16'(tot));
            end
            nseq++;
        end
        send_request(CMD_FINISH, 16'd0, 16'd0, 16'd0);
        i_s_tvalid <= 1'b0;
        stim_done = 1;
    end

    // Receiver side: random stalls plus one long hold while the sender keeps going.
    initial begin
        int wait_n;
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!long_hold && coded_q.size() > 4) begin
                long_hold = 1;
                i_m_tready <= 1'b0;
                repeat (600) @(posedge i_clk);
            end
            wait_n = $urandom_range(0, 4);
            if ($urandom_range(0, 3) == 0) wait_n = 0;
            if (wait_n != 0) begin
                i_m_tready <= 1'b0;
                repeat (wait_n - 1) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (coded_q.size() == 0) begin
                $error("unexpected byte %h", o_m_tdata);
                errors++;
            end else begin
                t_coded want;
                want = coded_q.pop_front();
                if (o_m_tdata !== want.code_byte) begin
                    $error("out_byte expected %h actual %h", want.code_byte, o_m_tdata);
                    errors++;
                end
                if (o_m_tlast !== want.last) begin
                    $error("last expected %b actual %b", want.last, o_m_tlast);
                    errors++;
                end
                if (o_m_tuser[0] !== want.ovf) begin
                    $error("overflow expected %b actual %b", want.ovf, o_m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    initial begin
        wait (stim_done);
        while (coded_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && coded_q.size() == 0) begin
            $display("[arithmetic_encoder_16bit_unit] OK");
        end else begin
            $display("[arithmetic_encoder_16bit_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("[arithmetic_encoder_16bit_unit] ERROR");
        $finish;
    end
endmodule

FILE: arithmetic_encoder_16bit_unit.f
hw/rtl/ae16_pkg.sv
hw/rtl/arithmetic_encoder_16bit_unit.sv
sim/tb_arithmetic_encoder_16bit_unit.sv
